// File: hw/rtl/effect_variance_threshold_binning_unit_defines.svh
// Assertion macros shared by the checker of the threshold binning unit.
// Holds macro definitions only; no dependencies.
`ifndef EFFECT_VARIANCE_THRESHOLD_BINNING_UNIT_DEFINES_SVH
`define EFFECT_VARIANCE_THRESHOLD_BINNING_UNIT_DEFINES_SVH

// Checked on every clock edge outside reset.
`define EVTB_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define EVTB_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

// File: hw/rtl/evtb_pkg.sv
// Package of the effect variance threshold binning unit: widths, defaults,
// the control state type and small helper functions. No dependencies.
`timescale 1ns / 1ps

package evtb_pkg;

   localparam int NUM_THRESHOLDS_DEF = 4;
   localparam int MAX_MARKERS_DEF    = 1048576;
   localparam int NUM_REGS           = 4;
   localparam int MAX_OUT            = 4;

   localparam int EFFECT_W = 24;
   localparam int PQ_W     = 16;
   localparam int VAR_W    = 32;
   localparam int GAMMA_W  = 32;
   localparam int MAG_W    = 24;
   localparam int SQ_W     = 47;
   localparam int GV_W     = 63;
   localparam int LIM_W    = 64;
   localparam int SUM_W    = 64;
   localparam int DVD_W    = 64;
   localparam int SHARE_W  = 17;
   localparam int MEAN_W   = 47;
   localparam int BIN_W    = 2;
   localparam int CSR_IDX_W = 3;

   localparam logic [SHARE_W-1:0] SHARE_MAX = SHARE_W'(65536);
   localparam logic [MEAN_W-1:0]  MEAN_MAX  = MEAN_W'(64'd1 << 46);

   typedef enum logic [3:0] {
      ST_RUN,
      ST_DRAIN,
      ST_FRAC,
      ST_FRAC_WAIT,
      ST_BIN,
      ST_SHARE,
      ST_SHARE_WAIT,
      ST_MEAN,
      ST_MEAN_WAIT,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic shift;
      logic clear;
   } cell_ctrl_type;

   function automatic logic [GAMMA_W-1:0] gamma_reset(input int idx);
      logic [GAMMA_W-1:0] val;
      case (idx)
         0: val = GAMMA_W'(0);
         1: val = GAMMA_W'(42950);
         2: val = GAMMA_W'(429497);
         3: val = GAMMA_W'(4294967);
         default: val = '1;
      endcase
      return val;
   endfunction

   function automatic logic [SHARE_W-1:0] clamp_share(input logic [DVD_W-1:0] q);
      return (q > DVD_W'(SHARE_MAX)) ? SHARE_MAX : q[SHARE_W-1:0];
   endfunction

   function automatic logic [MEAN_W-1:0] clamp_mean(input logic [DVD_W-1:0] q);
      return (q > DVD_W'(MEAN_MAX)) ? MEAN_MAX : q[MEAN_W-1:0];
   endfunction

endpackage

// File: hw/rtl/evtb_front.sv
// Front pipeline: effect magnitude, squared effect and 2pq times the square.
// Depends on evtb_pkg.
`timescale 1ns / 1ps

module evtb_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   input  logic signed [evtb_pkg::EFFECT_W-1:0] in_effect,
   input  logic [evtb_pkg::PQ_W-1:0]     in_two_pq,
   input  logic [evtb_pkg::VAR_W-1:0]    in_var,
   input  logic                          in_last,
   output logic                          out_valid,
   output logic                          out_last,
   output logic [evtb_pkg::GV_W-1:0]     out_gv,
   output logic [evtb_pkg::SQ_W-1:0]     out_sq,
   output logic [evtb_pkg::VAR_W-1:0]    out_var
);
   import evtb_pkg::*;

   logic              v1_ff, v2_ff, v3_ff;
   logic              l1_ff, l2_ff, l3_ff;
   logic [MAG_W-1:0]  mag_ff, mag_in;
   logic [PQ_W-1:0]   pq1_ff, pq2_ff;
   logic [VAR_W-1:0]  var1_ff, var2_ff, var3_ff;
   logic [SQ_W-1:0]   sq2_ff, sq3_ff;
   logic [2*MAG_W-1:0] sq_full;
   logic [GV_W-1:0]   gv3_ff;
   logic [PQ_W+SQ_W-1:0] gv_full;

   // Two's complement negation also gives the right magnitude for the most
   // negative effect when read as unsigned.
   assign mag_in  = in_effect[EFFECT_W-1] ? MAG_W'(~in_effect + 1'b1) : MAG_W'(in_effect);
   assign sq_full = mag_ff * mag_ff;
   assign gv_full = pq2_ff * sq2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      l1_ff   <= in_last;
      mag_ff  <= mag_in;
      pq1_ff  <= in_two_pq;
      var1_ff <= in_var;
      l2_ff   <= l1_ff;
      sq2_ff  <= sq_full[SQ_W-1:0];
      pq2_ff  <= pq1_ff;
      var2_ff <= var1_ff;
      l3_ff   <= l2_ff;
      gv3_ff  <= gv_full[GV_W-1:0];
      sq3_ff  <= sq2_ff;
      var3_ff <= var2_ff;
   end

   assign out_valid = v3_ff;
   assign out_last  = l3_ff;
   assign out_gv    = gv3_ff;
   assign out_sq    = sq3_ff;
   assign out_var   = var3_ff;

endmodule

// File: hw/rtl/evtb_cell.sv
// One threshold cell: forms gamma times variance, compares, accumulates, and
// passes the transaction on to its neighbor. Depends on evtb_pkg.
`timescale 1ns / 1ps

module evtb_cell #(
   parameter int MAX_MARKERS = evtb_pkg::MAX_MARKERS_DEF,
   parameter int CNT_W       = $clog2(MAX_MARKERS + 1)
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic [evtb_pkg::GAMMA_W-1:0] gamma,
   input  logic                         in_valid,
   input  logic                         in_last,
   input  logic [evtb_pkg::GV_W-1:0]    in_gv,
   input  logic [evtb_pkg::SQ_W-1:0]    in_sq,
   input  logic [evtb_pkg::VAR_W-1:0]   in_var,
   output logic                         out_valid,
   output logic                         out_last,
   output logic [evtb_pkg::GV_W-1:0]    out_gv,
   output logic [evtb_pkg::SQ_W-1:0]    out_sq,
   output logic [evtb_pkg::VAR_W-1:0]   out_var,
   input  evtb_pkg::cell_ctrl_type      ctrl,
   input  logic [CNT_W-1:0]             shift_cnt,
   input  logic [evtb_pkg::SUM_W-1:0]   shift_sum,
   output logic [CNT_W-1:0]             acc_cnt,
   output logic [evtb_pkg::SUM_W-1:0]   acc_sum
);
   import evtb_pkg::*;

   logic               va_ff, vb_ff;
   logic               la_ff, lb_ff;
   logic [GV_W-1:0]    gva_ff, gvb_ff;
   logic [SQ_W-1:0]    sqa_ff, sqb_ff;
   logic [VAR_W-1:0]   vara_ff, varb_ff;
   logic [LIM_W-1:0]   lim_ff;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [SUM_W-1:0]   sum_ff, sum_in;
   logic [SUM_W:0]     sum_add;
   logic               hit;

   // 2pq*beta^2 is Q1.62 and gamma*V is Q8.56, so the limit moves up six bits.
   assign hit     = va_ff && ({7'b0, gva_ff} > {lim_ff, 6'b0});
   assign sum_add = {1'b0, sum_ff} + (SUM_W + 1)'(sqa_ff);

   always_comb begin
      cnt_in = cnt_ff;
      sum_in = sum_ff;
      if (ctrl.clear) begin
         cnt_in = '0;
         sum_in = '0;
      end else if (ctrl.shift) begin
         cnt_in = shift_cnt;
         sum_in = shift_sum;
      end else if (hit) begin
         cnt_in = (cnt_ff < CNT_W'(MAX_MARKERS)) ? cnt_ff + 1'b1 : CNT_W'(MAX_MARKERS);
         sum_in = sum_add[SUM_W] ? '1 : sum_add[SUM_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff  <= 1'b0;
         vb_ff  <= 1'b0;
         cnt_ff <= '0;
         sum_ff <= '0;
      end else begin
         va_ff  <= in_valid;
         vb_ff  <= va_ff;
         cnt_ff <= cnt_in;
         sum_ff <= sum_in;
      end
   end

   always_ff @(posedge clock) begin
      la_ff   <= in_last;
      gva_ff  <= in_gv;
      sqa_ff  <= in_sq;
      vara_ff <= in_var;
      lim_ff  <= gamma * in_var;
      lb_ff   <= la_ff;
      gvb_ff  <= gva_ff;
      sqb_ff  <= sqa_ff;
      varb_ff <= vara_ff;
   end

   assign out_valid = vb_ff;
   assign out_last  = lb_ff;
   assign out_gv    = gvb_ff;
   assign out_sq    = sqb_ff;
   assign out_var   = varb_ff;
   assign acc_cnt   = cnt_ff;
   assign acc_sum   = sum_ff;

endmodule

// File: hw/rtl/evtb_div.sv
// Restoring divider, one quotient bit per cycle, shared by all result
// quotients. Depends on evtb_pkg.
`timescale 1ns / 1ps

module evtb_div #(
   parameter int DVS_W = 21
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [evtb_pkg::DVD_W-1:0] dividend,
   input  logic [DVS_W-1:0]           divisor,
   output logic                       done,
   output logic [evtb_pkg::DVD_W-1:0] quotient
);
   import evtb_pkg::*;

   localparam int STEP_W = $clog2(DVD_W);

   logic [DVD_W-1:0]  quo_ff, quo_in;
   logic [DVS_W-1:0]  rem_ff, rem_in;
   logic [DVS_W-1:0]  dvs_ff;
   logic [STEP_W-1:0] step_ff;
   logic              run_ff, done_ff;
   logic [DVS_W:0]    rem_sh, rem_sub;
   logic              ge;

   assign rem_sh  = {rem_ff, quo_ff[DVD_W-1]};
   assign rem_sub = rem_sh - {1'b0, dvs_ff};
   assign ge      = rem_sh >= {1'b0, dvs_ff};
   assign rem_in  = ge ? rem_sub[DVS_W-1:0] : rem_sh[DVS_W-1:0];
   assign quo_in  = {quo_ff[DVD_W-2:0], ge};

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            run_ff  <= 1'b1;
            step_ff <= '0;
         end else if (run_ff) begin
            step_ff <= step_ff + 1'b1;
            if (step_ff == STEP_W'(DVD_W - 1)) begin
               run_ff  <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= dividend;
         rem_ff <= '0;
         dvs_ff <= divisor;
      end else if (run_ff) begin
         quo_ff <= quo_in;
         rem_ff <= rem_in;
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// File: hw/rtl/effect_variance_threshold_binning_unit.sv
// Throughput: one marker transaction per cycle while a sample streams in.
// A marker passes the front pipeline registers and those of each cell before the last cell's accumulator takes it.
// After the last marker the input stalls until the last bin result is taken: pipeline
// drain, a division for the nonzero fraction, then per bin a share division and a
// mean-square division in the shared divider, each skipped when its divisor is zero.
// Reset (synchronous) clears counters and accumulators and loads the threshold defaults.
`timescale 1ns / 1ps

module effect_variance_threshold_binning_unit #(
   parameter int NUM_THRESHOLDS = evtb_pkg::NUM_THRESHOLDS_DEF,
   parameter int MAX_MARKERS    = evtb_pkg::MAX_MARKERS_DEF,
   parameter int CNT_W          = $clog2(MAX_MARKERS + 1)
) (
   input  logic                           clock,
   input  logic                           reset,
   // Marker input channel.
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic signed [evtb_pkg::EFFECT_W-1:0] req_effect,
   input  logic [evtb_pkg::PQ_W-1:0]      req_two_pq,
   input  logic [evtb_pkg::VAR_W-1:0]     req_gen_variance,
   input  logic                           req_last_marker,
   // Bin result channel.
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [evtb_pkg::BIN_W-1:0]     rsp_bin_index,
   output logic [CNT_W-1:0]               rsp_bin_count,
   output logic [evtb_pkg::SHARE_W-1:0]   rsp_bin_share,
   output logic [evtb_pkg::MEAN_W-1:0]    rsp_bin_mean_square,
   output logic [CNT_W-1:0]               rsp_nonzero_count,
   output logic [evtb_pkg::SHARE_W-1:0]   rsp_nonzero_fraction,
   output logic                           rsp_last_result,
   // Threshold register write channel.
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [evtb_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [evtb_pkg::GAMMA_W-1:0]   csr_wdata
);
   import evtb_pkg::*;

   localparam int NOUT = (NUM_THRESHOLDS < MAX_OUT) ? NUM_THRESHOLDS : MAX_OUT;

   state_type state_ff, state_in;

   logic [GAMMA_W-1:0] gamma_ff [NUM_THRESHOLDS];

   // Links of the cell chain; entry 0 is fed by the front pipeline.
   logic               lk_valid [NUM_THRESHOLDS+1];
   logic               lk_last  [NUM_THRESHOLDS+1];
   logic [GV_W-1:0]    lk_gv    [NUM_THRESHOLDS+1];
   logic [SQ_W-1:0]    lk_sq    [NUM_THRESHOLDS+1];
   logic [VAR_W-1:0]   lk_var   [NUM_THRESHOLDS+1];

   // Accumulators; the entry past the top cell reads as zero.
   logic [CNT_W-1:0]   acc_cnt  [NUM_THRESHOLDS+1];
   logic [SUM_W-1:0]   acc_sum  [NUM_THRESHOLDS+1];

   cell_ctrl_type      cell_ctrl;

   logic [CNT_W-1:0]   total_ff, total_in;
   logic [CNT_W-1:0]   nz_ff, nz_in;
   logic               accept, cnt_clear;

   logic [BIN_W-1:0]   bin_ff, bin_in;
   logic [CNT_W-1:0]   bcnt_ff, bcnt_in;
   logic [SUM_W-1:0]   bsum_ff, bsum_in;
   logic [SHARE_W-1:0] share_ff, share_in;
   logic [MEAN_W-1:0]  mean_ff, mean_in;
   logic [SHARE_W-1:0] frac_ff, frac_in;
   logic [CNT_W-1:0]   head_cnt;
   logic [SUM_W-1:0]   head_sum;

   logic               div_start, div_done;
   logic [DVD_W-1:0]   div_dvd, div_quo;
   logic [CNT_W-1:0]   div_dvs;

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_RUN);
   assign csr_ready = 1'b1;

   // Threshold registers. Thresholds past the writable set stay at all ones.
   for (genvar t = 0; t < NUM_THRESHOLDS; t++) begin : g_gamma
      always_ff @(posedge clock) begin
         if (reset) begin
            gamma_ff[t] <= gamma_reset(t);
         end else if (t < NUM_REGS && csr_valid && csr_ready
                      && csr_index == CSR_IDX_W'(t)) begin
            gamma_ff[t] <= csr_wdata;
         end
      end
   end

   evtb_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (accept),
      .in_effect (req_effect),
      .in_two_pq (req_two_pq),
      .in_var    (req_gen_variance),
      .in_last   (req_last_marker),
      .out_valid (lk_valid[0]),
      .out_last  (lk_last[0]),
      .out_gv    (lk_gv[0]),
      .out_sq    (lk_sq[0]),
      .out_var   (lk_var[0])
   );

   // One cell per threshold. During readout the accumulators shift toward
   // cell 0, so the head always sees the current bin and the one above it.
   for (genvar t = 0; t < NUM_THRESHOLDS; t++) begin : g_cell
      evtb_cell #(
         .MAX_MARKERS (MAX_MARKERS),
         .CNT_W       (CNT_W)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .gamma     (gamma_ff[t]),
         .in_valid  (lk_valid[t]),
         .in_last   (lk_last[t]),
         .in_gv     (lk_gv[t]),
         .in_sq     (lk_sq[t]),
         .in_var    (lk_var[t]),
         .out_valid (lk_valid[t+1]),
         .out_last  (lk_last[t+1]),
         .out_gv    (lk_gv[t+1]),
         .out_sq    (lk_sq[t+1]),
         .out_var   (lk_var[t+1]),
         .ctrl      (cell_ctrl),
         .shift_cnt (acc_cnt[t+1]),
         .shift_sum (acc_sum[t+1]),
         .acc_cnt   (acc_cnt[t]),
         .acc_sum   (acc_sum[t])
      );
   end

   assign acc_cnt[NUM_THRESHOLDS] = '0;
   assign acc_sum[NUM_THRESHOLDS] = '0;

   // Differencing of adjacent thresholds; a negative difference reads as zero.
   assign head_cnt = (acc_cnt[0] > acc_cnt[1]) ? acc_cnt[0] - acc_cnt[1] : '0;
   assign head_sum = (acc_sum[0] > acc_sum[1]) ? acc_sum[0] - acc_sum[1] : '0;

   evtb_div #(
      .DVS_W (CNT_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dvd),
      .divisor  (div_dvs),
      .done     (div_done),
      .quotient (div_quo)
   );

   // Sample counters, saturating at the marker limit.
   always_comb begin
      total_in = total_ff;
      nz_in    = nz_ff;
      if (cnt_clear) begin
         total_in = '0;
         nz_in    = '0;
      end else if (accept) begin
         if (total_ff < CNT_W'(MAX_MARKERS)) begin
            total_in = total_ff + 1'b1;
         end
         if (req_effect != '0 && nz_ff < CNT_W'(MAX_MARKERS)) begin
            nz_in = nz_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_RUN;
         total_ff <= '0;
         nz_ff    <= '0;
         bin_ff   <= '0;
      end else begin
         state_ff <= state_in;
         total_ff <= total_in;
         nz_ff    <= nz_in;
         bin_ff   <= bin_in;
      end
   end

   always_ff @(posedge clock) begin
      bcnt_ff  <= bcnt_in;
      bsum_ff  <= bsum_in;
      share_ff <= share_in;
      mean_ff  <= mean_in;
      frac_ff  <= frac_in;
   end

   // Control sequencer. Streaming until the last marker is taken, then wait
   // for it to leave the chain, then one result per bin with the quotients
   // worked out in the shared divider, or set to zero when the divisor is zero.
   always_comb begin
      state_in  = state_ff;
      div_start = 1'b0;
      div_dvd   = '0;
      div_dvs   = '0;
      cell_ctrl = '0;
      cnt_clear = 1'b0;
      bin_in    = bin_ff;
      bcnt_in   = bcnt_ff;
      bsum_in   = bsum_ff;
      share_in  = share_ff;
      mean_in   = mean_ff;
      frac_in   = frac_ff;
      case (state_ff)
         ST_RUN: begin
            if (accept && req_last_marker) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (lk_valid[NUM_THRESHOLDS] && lk_last[NUM_THRESHOLDS]) begin
               state_in = ST_FRAC;
            end
         end
         ST_FRAC: begin
            bin_in = '0;
            if (total_ff == '0) begin
               frac_in  = '0;
               state_in = ST_BIN;
            end else begin
               div_start = 1'b1;
               div_dvd   = DVD_W'(nz_ff) << 16;
               div_dvs   = total_ff;
               state_in  = ST_FRAC_WAIT;
            end
         end
         ST_FRAC_WAIT: begin
            if (div_done) begin
               frac_in  = clamp_share(div_quo);
               state_in = ST_BIN;
            end
         end
         ST_BIN: begin
            bcnt_in  = head_cnt;
            bsum_in  = head_sum;
            state_in = ST_SHARE;
         end
         ST_SHARE: begin
            if (nz_ff == '0) begin
               share_in = '0;
               state_in = ST_MEAN;
            end else begin
               div_start = 1'b1;
               div_dvd   = DVD_W'(bcnt_ff) << 16;
               div_dvs   = nz_ff;
               state_in  = ST_SHARE_WAIT;
            end
         end
         ST_SHARE_WAIT: begin
            if (div_done) begin
               share_in = clamp_share(div_quo);
               state_in = ST_MEAN;
            end
         end
         ST_MEAN: begin
            if (bcnt_ff == '0) begin
               mean_in  = '0;
               state_in = ST_OUT;
            end else begin
               div_start = 1'b1;
               div_dvd   = bsum_ff;
               div_dvs   = bcnt_ff;
               state_in  = ST_MEAN_WAIT;
            end
         end
         ST_MEAN_WAIT: begin
            if (div_done) begin
               mean_in  = clamp_mean(div_quo);
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (!rsp_stall) begin
               if (bin_ff == BIN_W'(NOUT - 1)) begin
                  // Final bin taken: clear the accumulators and counters for the next sample.
                  cell_ctrl.clear = 1'b1;
                  cnt_clear       = 1'b1;
                  state_in        = ST_RUN;
               end else begin
                  cell_ctrl.shift = 1'b1;
                  bin_in          = bin_ff + 1'b1;
                  state_in        = ST_BIN;
               end
            end
         end
         default: begin
            state_in = ST_RUN;
         end
      endcase
   end

   assign rsp_valid            = (state_ff == ST_OUT);
   assign rsp_bin_index        = bin_ff;
   assign rsp_bin_count        = bcnt_ff;
   assign rsp_bin_share        = share_ff;
   assign rsp_bin_mean_square  = mean_ff;
   assign rsp_nonzero_count    = nz_ff;
   assign rsp_nonzero_fraction = frac_ff;
   assign rsp_last_result      = (bin_ff == BIN_W'(NOUT - 1));

endmodule

// File: hw/rtl/evtb_checker.sv
// Port-level checker of the threshold binning unit and its bind statement.
// Depends on evtb_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "effect_variance_threshold_binning_unit_defines.svh"

module evtb_checker #(
   parameter int MAX_MARKERS = evtb_pkg::MAX_MARKERS_DEF,
   parameter int CNT_W       = $clog2(MAX_MARKERS + 1)
) (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_stall,
   input logic                         rsp_valid,
   input logic                         rsp_stall,
   input logic [CNT_W-1:0]             rsp_bin_count,
   input logic [CNT_W-1:0]             rsp_nonzero_count,
   input logic [evtb_pkg::SHARE_W-1:0] rsp_bin_share,
   input logic                         rsp_last_result
);
   import evtb_pkg::*;

   `EVTB_ASSERT_ALWAYS(a_no_rsp_after_reset, reset |=> !rsp_valid, "result after reset")
   `EVTB_ASSERT(a_stalled_rsp_holds, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_bin_count), "stalled result changed")
   `EVTB_ASSERT(a_input_held_in_readout, rsp_valid |-> req_stall, "input open during readout")
   `EVTB_ASSERT(a_bin_within_nonzero, rsp_valid |-> rsp_bin_count <= rsp_nonzero_count && rsp_bin_share <= SHARE_MAX, "bin exceeds nonzero count")
   `EVTB_ASSERT(a_gap_between_bins, rsp_valid && !rsp_stall && !rsp_last_result |=> !rsp_valid, "bins back to back")

endmodule

bind effect_variance_threshold_binning_unit evtb_checker #(
   .MAX_MARKERS (MAX_MARKERS),
   .CNT_W       (CNT_W)
) u_evtb_checker (.*);
